/* rtl/core/adc_register_access_framer_crc8_defines.svh */
// ----------------------------------------------------------------------------
// adc register access framer assertion macros
// shared property forms for the framer's checks
// ----------------------------------------------------------------------------
`ifndef ADC_REGISTER_ACCESS_FRAMER_CRC8_DEFINES_SVH
`define ADC_REGISTER_ACCESS_FRAMER_CRC8_DEFINES_SVH

// same-cycle implication
`define ARFC_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication
`define ARFC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

/* rtl/core/arfc_pkg.sv */
// ----------------------------------------------------------------------------
// arfc_pkg
// types, constants and crc helpers for the register access framer
// ----------------------------------------------------------------------------
`default_nettype none

package arfc_pkg;

   localparam int MAX_REG_BYTES = 4;
   // frame byte index covers command, data bytes and crc byte
   localparam int IDX_W = $clog2(MAX_REG_BYTES + 2);
   localparam int LEN_W = 3;

   localparam logic [7:0] CRC_SEED = 8'hFF;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   localparam logic KIND_TRANSMIT  = 1'b0;
   localparam logic KIND_READ_DONE = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_RX_BYTE = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_CRC_ENABLE    = 3'd0,
      CSR_CRC_POLY      = 3'd1,
      CSR_CRC_CHECK     = 3'd2,
      CSR_READ_CMD_BITS = 3'd3,
      CSR_WRITE_CMD_BITS = 3'd4
   } csr_index_type;

   // one byte through the crc-8 shift register, msb first
   function automatic logic [7:0] crc_fold(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // byte k of the write value, zero above bit 31
   function automatic logic [7:0] value_byte(input logic [31:0] value,
                                             input logic [LEN_W-1:0] k);
      logic [7:0] b;
      b = 8'h00;
      for (int j = 0; j < 4; j++) begin
         if (k == LEN_W'(j)) begin
            b = value[8*j +: 8];
         end
      end
      return b;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/adc_register_access_framer_crc8.sv */
// order: a taken request word is held in the work register, each result word in the
//   response register; throughput: a write sends 2 to 6 frame bytes (command,
//   data bytes, optional crc byte), one per cycle when the output register is free;
//   a read or received byte is a single step; sequencer and output register set the rate
// reset: synchronous active high; clears config to defaults, read state, crc seed
// ----------------------------------------------------------------------------
// adc_register_access_framer_crc8
// frames register reads and writes for a serial converter link with crc-8,
// collects read data bytes and reports the value and a crc error flag
// ----------------------------------------------------------------------------
`default_nettype none

module adc_register_access_framer_crc8 (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [5:0]  req_reg_address,
   input  wire logic [2:0]  req_reg_bytes,
   input  wire logic [31:0] req_write_value,
   input  wire logic [7:0]  req_received_byte,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_transmit_byte,
   output logic             rsp_frame_last,
   output logic [31:0]      rsp_read_value,
   output logic             rsp_crc_error,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int IDX_W = arfc_pkg::IDX_W;
   localparam int LEN_W = arfc_pkg::LEN_W;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic       crc_enable_ff;
   logic [7:0] crc_poly_ff;
   logic [7:0] crc_check_ff;
   logic [7:0] read_cmd_bits_ff;
   logic [7:0] write_cmd_bits_ff;
   logic       csr_write;
   arfc_pkg::csr_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = arfc_pkg::csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enable_ff     <= 1'b0;
         crc_poly_ff       <= 8'h07;
         crc_check_ff      <= 8'h00;
         read_cmd_bits_ff  <= 8'h40;
         write_cmd_bits_ff <= 8'h00;
      end else if (csr_write) begin
         unique case (csr_index)
            arfc_pkg::CSR_CRC_ENABLE:     crc_enable_ff     <= pwdata[0];
            arfc_pkg::CSR_CRC_POLY:       crc_poly_ff       <= pwdata[7:0];
            arfc_pkg::CSR_CRC_CHECK:      crc_check_ff      <= pwdata[7:0];
            arfc_pkg::CSR_READ_CMD_BITS:  read_cmd_bits_ff  <= pwdata[7:0];
            arfc_pkg::CSR_WRITE_CMD_BITS: write_cmd_bits_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register readback, addresses past the list read as zero
   always_comb begin
      unique case (csr_index)
         arfc_pkg::CSR_CRC_ENABLE:     prdata = {31'd0, crc_enable_ff};
         arfc_pkg::CSR_CRC_POLY:       prdata = {24'd0, crc_poly_ff};
         arfc_pkg::CSR_CRC_CHECK:      prdata = {24'd0, crc_check_ff};
         arfc_pkg::CSR_READ_CMD_BITS:  prdata = {24'd0, read_cmd_bits_ff};
         arfc_pkg::CSR_WRITE_CMD_BITS: prdata = {24'd0, write_cmd_bits_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // work register: holds the request word being framed
   // ---------------------------------------------------------------------
   logic             busy_ff, busy_in;
   logic [1:0]       op_ff;
   logic [5:0]       addr_ff;
   logic [LEN_W-1:0] len_ff;
   logic [31:0]      wval_ff;
   logic [7:0]       rx_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       wcrc_ff, wcrc_in;
   logic [LEN_W-1:0] len_clamped;

   // read reception state
   logic             read_pending_ff, read_pending_in;
   logic [LEN_W-1:0] bytes_expected_ff, bytes_expected_in;
   logic [LEN_W-1:0] bytes_received_ff, bytes_received_in;
   logic [31:0]      value_acc_ff, value_acc_in;
   logic [7:0]       crc_acc_ff, crc_acc_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff;
   logic [7:0]       rsp_tx_ff;
   logic             rsp_last_ff;
   logic [31:0]      rsp_value_ff;
   logic             rsp_err_ff;

   // step outputs
   logic             out_free;
   logic             step_fire;
   logic             step_done;
   logic             step_emit;
   logic             step_kind;
   logic [7:0]       step_tx;
   logic             step_last;
   logic [31:0]      step_value;
   logic             step_err;
   logic             req_take;

   // frame bookkeeping for a write
   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] len_idx;
   logic [7:0]       write_cmd;
   logic [7:0]       read_cmd;
   logic [7:0]       wr_byte;
   logic [7:0]       rx_crc;

   // reg_bytes of zero is one byte, above the maximum is the maximum
   always_comb begin
      if (req_reg_bytes == '0) begin
         len_clamped = LEN_W'(1);
      end else if (req_reg_bytes > LEN_W'(arfc_pkg::MAX_REG_BYTES)) begin
         len_clamped = LEN_W'(arfc_pkg::MAX_REG_BYTES);
      end else begin
         len_clamped = req_reg_bytes;
      end
   end

   // a step runs whenever a word is held and the response register can take a word
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_fire = busy_ff && out_free;
   // next request word can enter as the current one finishes
   assign req_ready = !busy_ff || (step_fire && step_done);
   assign req_take  = req_valid && req_ready;

   assign len_idx   = IDX_W'(len_ff);
   assign last_idx  = len_idx + IDX_W'(crc_enable_ff);
   assign write_cmd = write_cmd_bits_ff | {2'b00, addr_ff};
   assign read_cmd  = read_cmd_bits_ff | {2'b00, addr_ff};
   assign rx_crc    = arfc_pkg::crc_fold(crc_acc_ff, rx_ff, crc_poly_ff);

   // data bytes go out most significant first
   always_comb begin
      if (idx_ff == '0) begin
         wr_byte = write_cmd;
      end else if (idx_ff <= len_idx) begin
         wr_byte = arfc_pkg::value_byte(wval_ff, len_ff - LEN_W'(idx_ff));
      end else begin
         wr_byte = ~wcrc_ff;
      end
   end

   // one step of the framer
   always_comb begin
      step_done         = 1'b1;
      step_emit         = 1'b0;
      step_kind         = arfc_pkg::KIND_TRANSMIT;
      step_tx           = 8'h00;
      step_last         = 1'b0;
      step_value        = 32'd0;
      step_err          = 1'b0;
      wcrc_in           = wcrc_ff;
      read_pending_in   = read_pending_ff;
      bytes_expected_in = bytes_expected_ff;
      bytes_received_in = bytes_received_ff;
      value_acc_in      = value_acc_ff;
      crc_acc_in        = crc_acc_ff;
      case (arfc_pkg::opcode_type'(op_ff))
         arfc_pkg::OP_WRITE: begin
            step_emit = 1'b1;
            step_tx   = wr_byte;
            step_last = (idx_ff == last_idx);
            step_done = step_last;
            // command byte folds into the seed, data bytes into the running crc
            if (idx_ff == '0) begin
               wcrc_in = arfc_pkg::crc_fold(arfc_pkg::CRC_SEED, write_cmd, crc_poly_ff);
            end else begin
               wcrc_in = arfc_pkg::crc_fold(wcrc_ff, wr_byte, crc_poly_ff);
            end
         end
         arfc_pkg::OP_READ: begin
            step_emit         = 1'b1;
            step_tx           = read_cmd;
            step_last         = 1'b1;
            read_pending_in   = 1'b1;
            bytes_expected_in = len_ff;
            bytes_received_in = '0;
            value_acc_in      = 32'd0;
            crc_acc_in        = arfc_pkg::crc_fold(arfc_pkg::CRC_SEED, read_cmd, crc_poly_ff);
         end
         arfc_pkg::OP_RX_BYTE: begin
            // a byte with no read pending is dropped
            if (read_pending_ff) begin
               crc_acc_in = rx_crc;
               if (bytes_received_ff < bytes_expected_ff) begin
                  value_acc_in      = {value_acc_ff[23:0], rx_ff};
                  bytes_received_in = bytes_received_ff + LEN_W'(1);
                  step_emit         = (bytes_received_in == bytes_expected_ff)
                                      && !crc_enable_ff;
               end else begin
                  // byte past the data is the crc byte
                  step_emit = 1'b1;
               end
               if (step_emit) begin
                  read_pending_in = 1'b0;
               end
               step_kind  = arfc_pkg::KIND_READ_DONE;
               step_value = value_acc_in;
               step_err   = crc_enable_ff && (rx_crc != crc_check_ff);
            end
         end
         default: ;  // unused opcode, no word out
      endcase
   end

   assign busy_in = req_take ? 1'b1 : (step_fire && step_done) ? 1'b0 : busy_ff;
   assign idx_in  = req_take ? '0 : step_fire ? idx_ff + IDX_W'(1) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff <= idx_in;
      if (req_take) begin
         op_ff   <= req_opcode;
         addr_ff <= req_reg_address;
         len_ff  <= len_clamped;
         wval_ff <= req_write_value;
         rx_ff   <= req_received_byte;
      end
      if (step_fire) begin
         wcrc_ff <= wcrc_in;
      end
   end

   // read reception state
   always_ff @(posedge clock) begin
      if (reset) begin
         read_pending_ff   <= 1'b0;
         bytes_expected_ff <= '0;
         bytes_received_ff <= '0;
         value_acc_ff      <= 32'd0;
         crc_acc_ff        <= arfc_pkg::CRC_SEED;
      end else if (step_fire) begin
         read_pending_ff   <= read_pending_in;
         bytes_expected_ff <= bytes_expected_in;
         bytes_received_ff <= bytes_received_in;
         value_acc_ff      <= value_acc_in;
         crc_acc_ff        <= crc_acc_in;
      end
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   assign rsp_valid_in = (step_fire && step_emit) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step_fire && step_emit) begin
         rsp_kind_ff  <= step_kind;
         rsp_tx_ff    <= step_tx;
         rsp_last_ff  <= step_last;
         rsp_value_ff <= step_value;
         rsp_err_ff   <= step_err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_transmit_byte = rsp_tx_ff;
   assign rsp_frame_last    = rsp_last_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_crc_error     = rsp_err_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
`include "adc_register_access_framer_crc8_defines.svh"

   `ARFC_ASSERT_NOW(a_hold_mid_frame, clock, reset, busy_ff && !(step_fire && step_done), !req_ready, "request taken while a frame is still being sent")
   `ARFC_ASSERT_NEXT(a_take_loads_work, clock, reset, req_valid && req_ready, busy_ff, "taken request word not held for framing")
   `ARFC_ASSERT_NOW(a_rx_count_bound, clock, reset, read_pending_ff, bytes_received_ff <= bytes_expected_ff, "more data bytes received than expected")
   `ARFC_ASSERT_NEXT(a_done_clears_read, clock, reset, step_fire && step_emit && (step_kind == arfc_pkg::KIND_READ_DONE), !read_pending_ff, "read still pending after completion")
   `ARFC_ASSERT_NOW(a_write_idx_bound, clock, reset, busy_ff && (op_ff == arfc_pkg::OP_WRITE), idx_ff <= last_idx, "write frame index past the last byte")

endmodule

`default_nettype wire

/* test/adc_register_access_framer_crc8_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_register_access_framer_crc8_tb
// self-checking bench for the crc-8 register access framer: a directed table
// of accesses and received bytes, then random read and write frames under
// several crc settings; every response word is checked against a predictor
// ----------------------------------------------------------------------------

module adc_register_access_framer_crc8_tb;

   // opcode with no meaning, the block must ignore it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 130;
   localparam int PHASE_ITEMS   = 32;
   // quiet cycles before a register write, covers words that give no result
   localparam int SETTLE_CYCLES = 8;
   // cycles with no handshake on any port before the run is declared hung
   localparam int STALL_LIMIT   = 500;

   // one word on the response channel
   typedef struct packed {
      logic        kind;
      logic [7:0]  tx;
      logic        last;
      logic [31:0] value;
      logic        err;
   } frame_word;

   // one row of the directed table: a register write or a request word,
   // with the first response word typed in where it is obvious
   typedef struct packed {
      bit                      is_csr;
      arfc_pkg::csr_index_type reg_idx;
      logic [1:0]              op;
      logic [5:0]              addr;
      logic [2:0]              nbytes;
      logic [31:0]             wval;
      logic [7:0]              rx;
      bit                      typed;
      frame_word               want;
   } plan_row;

   localparam frame_word NO_WORD = '0;
   localparam int NUM_PLAN = 31;

   // reset config: crc off, polynomial 7, check code 0, read bits 0x40, write bits 0
   localparam plan_row PLAN [NUM_PLAN] = '{
      // plain read of one byte, then its data byte
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 0, 1, 'h0, 'h00, 1,
        '{arfc_pkg::KIND_TRANSMIT, 'h40, 1, 'h0, 0}},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'hA5, 1,
        '{arfc_pkg::KIND_READ_DONE, 0, 0, 'hA5, 0}},
      // stray byte with no read armed, then the unused opcode
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 'h3F, 7, 'hFFFF_FFFF, 'h11, 0,
        NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, OP_UNUSED, 'h3F, 7, 'hFFFF_FFFF, 'hFF, 0, NO_WORD},
      // widest write, and a length above the maximum clamped to four bytes
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_WRITE, 'h3F, 4, 'hFFFF_FFFF, 'h00, 1,
        '{arfc_pkg::KIND_TRANSMIT, 'h3F, 0, 0, 0}},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_WRITE, 'h15, 7, 'h0102_0304, 'h00, 1,
        '{arfc_pkg::KIND_TRANSMIT, 'h15, 0, 0, 0}},
      // four byte read with extreme data
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 'h3F, 4, 'h0, 'h00, 1,
        '{arfc_pkg::KIND_TRANSMIT, 'h7F, 1, 'h0, 0}},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'hFF, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h80, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h01, 1,
        '{arfc_pkg::KIND_READ_DONE, 0, 0, 'h00FF_8001, 0}},
      // new read while one is half received restarts reception
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 1, 2, 'h0, 'h00, 1,
        '{arfc_pkg::KIND_TRANSMIT, 'h41, 1, 'h0, 0}},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h12, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 2, 1, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h5A, 1,
        '{arfc_pkg::KIND_READ_DONE, 0, 0, 'h5A, 0}},
      // write in the middle of a read leaves reception alone
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 3, 2, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'hDE, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_WRITE, 5, 1, 'h0000_00AA, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'hAD, 1,
        '{arfc_pkg::KIND_READ_DONE, 0, 0, 'hDEAD, 0}},
      // zero length read is taken as one byte
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 4, 0, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h77, 1,
        '{arfc_pkg::KIND_READ_DONE, 0, 0, 'h77, 0}},
      // crc switched on between data bytes: a crc byte is then awaited
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 6, 2, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h01, 0, NO_WORD},
      '{1, arfc_pkg::CSR_CRC_ENABLE, 0, 0, 0, 'h1, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h02, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h33, 0, NO_WORD},
      // write with crc byte appended
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_WRITE, 7, 2, 'h0000_BEEF, 'h00, 0, NO_WORD},
      // crc switched off after all data is in: next byte closes the read
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_READ, 9, 1, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h20, 0, NO_WORD},
      '{1, arfc_pkg::CSR_CRC_ENABLE, 0, 0, 0, 'h0, 'h00, 0, NO_WORD},
      '{0, arfc_pkg::CSR_CRC_ENABLE, arfc_pkg::OP_RX_BYTE, 0, 0, 'h0, 'h99, 1,
        '{arfc_pkg::KIND_READ_DONE, 0, 0, 'h20, 0}}
   };

   // block ports, all driven to known values from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [5:0]  req_reg_address = '0;
   logic [2:0]  req_reg_bytes = '0;
   logic [31:0] req_write_value = '0;
   logic [7:0]  req_received_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_transmit_byte;
   logic        rsp_frame_last;
   logic [31:0] rsp_read_value;
   logic        rsp_crc_error;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // hand-typed first response word, travels with the request word
   bit          tag_typed = 1'b0;
   frame_word   tag_word = '0;

   // predictor copy of the registers
   logic        cfg_crc_en;
   logic [7:0]  cfg_poly;
   logic [7:0]  cfg_check;
   logic [7:0]  cfg_read_bits;
   logic [7:0]  cfg_write_bits;

   // predictor copy of the read reception state
   bit          rx_armed;
   logic [2:0]  rx_len;
   logic [2:0]  rx_count;
   logic [31:0] rx_value;
   logic [7:0]  rx_crc;

   frame_word   due_words [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   adc_register_access_framer_crc8 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_reg_address   (req_reg_address),
      .req_reg_bytes     (req_reg_bytes),
      .req_write_value   (req_write_value),
      .req_received_byte (req_received_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_transmit_byte (rsp_transmit_byte),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_read_value    (rsp_read_value),
      .rsp_crc_error     (rsp_crc_error),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // crc-8, msb first, top bit of the polynomial implicit
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ cfg_poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // wait before a word: often short, sometimes long, none in calm stretches
   function automatic int draw_wait(input bit calm);
      if (calm) begin
         return 0;
      end
      if ($urandom_range(3, 0) == 0) begin
         return $urandom_range(16, 0);
      end
      return $urandom_range(2, 0);
   endfunction

   // works out the response words of one accepted request word
   task automatic frame_model(input logic [1:0] op, input logic [5:0] addr,
                              input logic [2:0] nb, input logic [31:0] wval,
                              input logic [7:0] rx);
      int         len;
      logic [7:0] cmd;
      logic [7:0] crc;
      logic [7:0] b;
      bit         done;
      frame_word  w;
      // out of range lengths are clamped to 1..max
      len = (nb == 3'd0) ? 1 : (int'(nb) > arfc_pkg::MAX_REG_BYTES) ? arfc_pkg::MAX_REG_BYTES
                                                                    : int'(nb);
      case (op)
         arfc_pkg::OP_WRITE: begin
            cmd = cfg_write_bits | {2'b00, addr};
            crc = crc8_step(arfc_pkg::CRC_SEED, cmd);
            w = '{arfc_pkg::KIND_TRANSMIT, cmd, 1'b0, 32'h0, 1'b0};
            due_words.push_back(w);
            // data bytes, most significant first
            for (int i = 0; i < len; i++) begin
               b = wval[8*(len-1-i) +: 8];
               crc = crc8_step(crc, b);
               w = '{arfc_pkg::KIND_TRANSMIT, b, 1'b0, 32'h0, 1'b0};
               due_words.push_back(w);
            end
            if (cfg_crc_en) begin
               w = '{arfc_pkg::KIND_TRANSMIT, ~crc, 1'b0, 32'h0, 1'b0};
               due_words.push_back(w);
            end
            // mark the closing byte of the frame
            w = due_words.pop_back();
            w.last = 1'b1;
            due_words.push_back(w);
         end
         arfc_pkg::OP_READ: begin
            cmd = cfg_read_bits | {2'b00, addr};
            rx_armed = 1'b1;
            rx_len = 3'(len);
            rx_count = 3'd0;
            rx_value = 32'h0;
            rx_crc = crc8_step(arfc_pkg::CRC_SEED, cmd);
            w = '{arfc_pkg::KIND_TRANSMIT, cmd, 1'b1, 32'h0, 1'b0};
            due_words.push_back(w);
         end
         arfc_pkg::OP_RX_BYTE: begin
            // bytes with no read armed are dropped
            if (rx_armed) begin
               rx_crc = crc8_step(rx_crc, rx);
               if (rx_count < rx_len) begin
                  rx_value = {rx_value[23:0], rx};
                  rx_count = rx_count + 3'd1;
                  done = (rx_count == rx_len) && !cfg_crc_en;
               end else begin
                  // past the data bytes: this is the crc byte
                  done = 1'b1;
               end
               if (done) begin
                  rx_armed = 1'b0;
                  w = '{arfc_pkg::KIND_READ_DONE, 8'h00, 1'b0, rx_value,
                        cfg_crc_en && (rx_crc != cfg_check)};
                  due_words.push_back(w);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // one request word: optional gap, then valid held until taken
   task automatic send_word(input logic [1:0] op, input logic [5:0] addr,
                            input logic [2:0] nb, input logic [31:0] wval,
                            input logic [7:0] rx, input bit typed, input frame_word want);
      int gap;
      gap = draw_wait(req_calm);
      if ($urandom_range(19, 0) == 0) begin
         req_calm = !req_calm;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_reg_address <= addr;
      req_reg_bytes <= nb;
      req_write_value <= wval;
      req_received_byte <= rx;
      tag_typed <= typed;
      tag_word <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and wait for every response word still due
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write with the block idle: setup cycle, access cycle
   task automatic csr_write(input arfc_pkg::csr_index_type idx, input logic [31:0] value);
      settle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // let the predictor pick up the new value before it is used
      @(posedge clock);
   endtask

   // predictor and scoreboard, all sampled at the rising edge
   always @(posedge clock) begin
      int        base;
      frame_word w;
      if (reset) begin
         cfg_crc_en = 1'b0;
         cfg_poly = 8'h07;
         cfg_check = 8'h00;
         cfg_read_bits = 8'h40;
         cfg_write_bits = 8'h00;
         rx_armed = 1'b0;
         rx_len = 3'd0;
         rx_count = 3'd0;
         rx_value = 32'h0;
         rx_crc = arfc_pkg::CRC_SEED;
      end else begin
         if (req_valid && req_ready) begin
            base = due_words.size();
            frame_model(req_opcode, req_reg_address, req_reg_bytes, req_write_value,
                        req_received_byte);
            // a hand-typed first word stands in for the predicted one
            if (tag_typed && due_words.size() > base) begin
               due_words[base] = tag_word;
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (arfc_pkg::csr_index_type'(paddr[4:2]))
               arfc_pkg::CSR_CRC_ENABLE:     cfg_crc_en = pwdata[0];
               arfc_pkg::CSR_CRC_POLY:       cfg_poly = pwdata[7:0];
               arfc_pkg::CSR_CRC_CHECK:      cfg_check = pwdata[7:0];
               arfc_pkg::CSR_READ_CMD_BITS:  cfg_read_bits = pwdata[7:0];
               arfc_pkg::CSR_WRITE_CMD_BITS: cfg_write_bits = pwdata[7:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               $display("%0t: word expected none actual kind %0d tx %h value %h",
                        $time, rsp_kind, rsp_transmit_byte, rsp_read_value);
               mismatches++;
            end else begin
               w = due_words.pop_front();
               compare_field("kind", 32'(w.kind), 32'(rsp_kind));
               compare_field("transmit_byte", 32'(w.tx), 32'(rsp_transmit_byte));
               compare_field("frame_last", 32'(w.last), 32'(rsp_frame_last));
               compare_field("read_value", w.value, rsp_read_value);
               compare_field("crc_error", 32'(w.err), 32'(rsp_crc_error));
            end
         end
      end
   end

   // watchdog: ends a run where no port moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stall before each word, calm stretches too
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if ($urandom_range(24, 0) == 0) begin
            rsp_calm = !rsp_calm;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // request side: directed table, then random frames in phases
   initial begin
      int          count;
      int          phase;
      int          next_cfg_at;
      int          pick;
      int          eff;
      int          sent;
      int          k;
      bit          cut;
      logic [5:0]  addr;
      logic [2:0]  nb;
      logic [7:0]  cmd;
      logic [7:0]  acc;
      logic [7:0]  rx;
      logic [31:0] wval;
      logic [31:0] knobs [5];

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < NUM_PLAN; i++) begin
         if (PLAN[i].is_csr) begin
            csr_write(PLAN[i].reg_idx, PLAN[i].wval);
         end else begin
            send_word(PLAN[i].op, PLAN[i].addr, PLAN[i].nbytes, PLAN[i].wval, PLAN[i].rx,
                      PLAN[i].typed, PLAN[i].want);
         end
      end

      // random part, register settings change every phase
      count = 0;
      phase = 0;
      next_cfg_at = 0;
      while (count < RANDOM_ITEMS) begin
         if (count >= next_cfg_at) begin
            // enable, polynomial, check code, read bits, write bits
            case (phase)
               0: knobs = '{1, 'h07, 'h00, 'h80, 'h00};
               1: knobs = '{1, 'hFF, 'hFF, 'hFF, 'hFF};
               2: knobs = '{0, 'h00, 'h00, 'h00, 'h00};
               default: begin
                  knobs[0] = $urandom_range(1, 0);
                  for (k = 1; k < 5; k++) begin
                     knobs[k] = $urandom_range(255, 0);
                  end
               end
            endcase
            // each write waits for the block to drain first
            for (k = 0; k < 5; k++) begin
               csr_write(arfc_pkg::csr_index_type'(k), knobs[k]);
            end
            phase++;
            next_cfg_at = count + PHASE_ITEMS;
         end

         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            // read frame: command, data bytes, crc byte when enabled
            addr = 6'($urandom_range(63, 0));
            nb = ($urandom_range(7, 0) == 0) ? 3'($urandom_range(7, 0))
                                              : 3'($urandom_range(4, 1));
            eff = (nb == 3'd0) ? 1
                : (int'(nb) > arfc_pkg::MAX_REG_BYTES) ? arfc_pkg::MAX_REG_BYTES : int'(nb);
            cmd = cfg_read_bits | {2'b00, addr};
            acc = crc8_step(arfc_pkg::CRC_SEED, cmd);
            send_word(arfc_pkg::OP_READ, addr, nb, $urandom(), 8'($urandom_range(255, 0)),
                      0, NO_WORD);
            count++;
            // now and then a frame is cut short and left for the next read
            cut = ($urandom_range(9, 0) == 0);
            sent = cut ? $urandom_range(eff - 1, 0) : eff;
            for (k = 0; k < sent; k++) begin
               if ($urandom_range(11, 0) == 0) begin
                  send_word(arfc_pkg::OP_WRITE, 6'($urandom_range(63, 0)),
                            3'($urandom_range(7, 0)), $urandom(),
                            8'($urandom_range(255, 0)), 0, NO_WORD);
                  count++;
               end
               rx = ($urandom_range(7, 0) == 0) ? ($urandom_range(1, 0) ? 8'hFF : 8'h00)
                                                : 8'($urandom_range(255, 0));
               acc = crc8_step(acc, rx);
               send_word(arfc_pkg::OP_RX_BYTE, 6'($urandom_range(63, 0)),
                         3'($urandom_range(7, 0)), $urandom(), rx, 0, NO_WORD);
               count++;
            end
            if (!cut && cfg_crc_en) begin
               // mostly a crc byte that lands on the check code, else a random one
               rx = 8'($urandom_range(255, 0));
               if ($urandom_range(2, 0) != 0) begin
                  for (k = 0; k < 256; k++) begin
                     if (crc8_step(acc, 8'(k)) == cfg_check) begin
                        rx = 8'(k);
                     end
                  end
               end
               send_word(arfc_pkg::OP_RX_BYTE, 6'($urandom_range(63, 0)),
                         3'($urandom_range(7, 0)), $urandom(), rx, 0, NO_WORD);
               count++;
            end
         end else if (pick < 85) begin
            // write access with edge values mixed in
            case ($urandom_range(7, 0))
               0: wval = 32'h0000_0000;
               1: wval = 32'hFFFF_FFFF;
               default: wval = $urandom();
            endcase
            nb = ($urandom_range(5, 0) == 0) ? 3'($urandom_range(7, 0))
                                              : 3'($urandom_range(4, 1));
            send_word(arfc_pkg::OP_WRITE, 6'($urandom_range(63, 0)), nb, wval,
                      8'($urandom_range(255, 0)), 0, NO_WORD);
            count++;
         end else if (pick < 95) begin
            // loose received byte, usually with no read armed
            send_word(arfc_pkg::OP_RX_BYTE, 6'($urandom_range(63, 0)),
                      3'($urandom_range(7, 0)), $urandom(), 8'($urandom_range(255, 0)),
                      0, NO_WORD);
            count++;
         end else begin
            send_word(OP_UNUSED, 6'($urandom_range(63, 0)), 3'($urandom_range(7, 0)),
                      $urandom(), 8'($urandom_range(255, 0)), 0, NO_WORD);
            count++;
         end
      end

      // drain, then a short tail to catch stray words
      settle();
      repeat (12) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
